// File: rtl/spq_pkg.sv
// package for the sorted priority queue: beat payload types, op codes,
// controller states and the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned ID_W = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   item_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic              was_empty;
    logic              was_full;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the accepted request beat
    logic do_insert;
    logic do_remove;
    logic flag_full;
    logic flag_empty;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
  } stat_t;

endpackage

// File: rtl/sorted_priority_queue.sv
// sorted priority queue, top level
// holds spq_ctrl and spq_datapath; depends on spq_pkg
//
// Request channel (req_valid/req_ready/req): op 0 inserts item_id with
// priority_req, op 1 removes the front entry. Entries are kept in ascending
// priority order; equal priorities leave in arrival order.
// Response channel (rsp_valid/rsp_ready/rsp): one beat per request with the
// removed entry (zeros otherwise), the empty/full flags and the occupancy.
// An insert into a full queue or a remove from an empty one leaves the queue
// unchanged and raises the matching flag.
// Sequencing: a request is latched in the idle state and applied to every
// cell in parallel in the exec state, which also loads the response
// register and raises rsp_valid; the two-state sequencer takes no new
// request until it is back in idle.
// A new request is taken while the previous response still waits; if the
// receiver stalls, the block holds the next request until the response
// register frees, then continues.
// Reset (rst, synchronous) empties the queue and drops any pending response.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// File: rtl/spq_ctrl.sv
// controller for the sorted priority queue: two-state sequencer and response valid
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            rsp_free;
  logic            exec;

  assign rsp_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    exec       = 1'b0;
    cmd        = '0;
    case (state)
      spq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        // wait here until the response register can take the result
        if (rsp_free) begin
          exec       = 1'b1;
          state_next = spq_pkg::ST_IDLE;
          if (stat.is_remove) begin
            cmd.flag_empty = stat.empty;
            cmd.do_remove  = !stat.empty;
          end else begin
            cmd.flag_full = stat.full;
            cmd.do_insert = !stat.full;
          end
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/spq_datapath.sv
// datapath for the sorted priority queue: row of sorted cells, fill count,
// request latch and response register
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::req_t  req,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat,
  output spq_pkg::rsp_t  rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_pkg::req_t                 cur;
  logic [CW-1:0]                 count;
  logic [spq_pkg::ID_W-1:0]      ids   [DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    prios [DEPTH];
  logic [DEPTH-1:0]              gt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  assign stat.is_remove = (cur.op == spq_pkg::OP_REMOVE);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.empty     = (count == '0);

  // held cells ranking strictly behind the new entry; ties stay in front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign gt[i] = (CW'(i) < count) && (prios[i] > cur.priority_req);

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (gt[i]) begin
          if (i == 0) begin
            ids[i]   <= cur.item_id;
            prios[i] <= cur.priority_req;
          end else if (!gt[(i == 0) ? 0 : i-1]) begin
            ids[i]   <= cur.item_id;
            prios[i] <= cur.priority_req;
          end else begin
            ids[i]   <= ids[(i == 0) ? 0 : i-1];
            prios[i] <= prios[(i == 0) ? 0 : i-1];
          end
        end else if (CW'(i) == count) begin
          // first free cell takes the old tail when the new entry goes ahead of it
          if ((i != 0) && gt[(i == 0) ? 0 : i-1]) begin
            ids[i]   <= ids[(i == 0) ? 0 : i-1];
            prios[i] <= prios[(i == 0) ? 0 : i-1];
          end else begin
            ids[i]   <= cur.item_id;
            prios[i] <= cur.priority_req;
          end
        end
      end else if (cmd.do_remove && (i < DEPTH - 1)) begin
        ids[i]   <= ids[(i < DEPTH - 1) ? i+1 : i];
        prios[i] <= prios[(i < DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert) begin
      count <= count + CW'(1);
    end else if (cmd.do_remove) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert || cmd.do_remove || cmd.flag_full || cmd.flag_empty) begin
      rsp.out_id       <= cmd.do_remove ? ids[0] : '0;
      rsp.out_priority <= cmd.do_remove ? prios[0] : '0;
      rsp.was_empty    <= cmd.flag_empty;
      rsp.was_full     <= cmd.flag_full;
      if (cmd.do_insert) begin
        rsp.occupancy <= spq_pkg::OCC_W'(count + CW'(1));
      end else if (cmd.do_remove) begin
        rsp.occupancy <= spq_pkg::OCC_W'(count - CW'(1));
      end else begin
        rsp.occupancy <= spq_pkg::OCC_W'(count);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_insert, cmd.do_remove, cmd.flag_full, cmd.flag_empty}))
    else $error("more than one action in a cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  a_remove_front: assert property (@(posedge clk) disable iff (rst)
    cmd.do_remove |=> rsp.out_id == $past(ids[0]) && count == $past(count) - CW'(1))
    else $error("remove did not return the front entry");

endmodule

// File: tb/tb.sv
// testbench for sorted_priority_queue: directed, back-pressure and random tests,
// each response beat checked against an in-bench model of the sorted queue
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned QDEPTH = spq_pkg::DEPTH_DEFAULT;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [spq_pkg::ID_W-1:0]   id;
    logic [spq_pkg::PRIO_W-1:0] prio;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  spq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  spq_pkg::rsp_t rsp;

  entry_t        queue_entries[$];   // model contents, front = next served
  spq_pkg::rsp_t pending_rsp[$];
  int unsigned errors = 0;
  int unsigned src_idle_max = 0;
  int unsigned snk_idle_max = 0;
  int unsigned hold_request = 0;
  int unsigned n_beats = 0;
  int unsigned n_insert = 0;
  int unsigned n_rejected = 0;
  int unsigned n_remove = 0;
  int unsigned n_empty = 0;
  int unsigned n_full_reached = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // applies one request to the model queue and returns the response it should give
  function automatic spq_pkg::rsp_t queue_update(spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    int            pos;
    res = '0;
    if (r.op == spq_pkg::OP_INSERT) begin
      n_insert++;
      if (queue_entries.size() >= QDEPTH) begin
        res.was_full = 1'b1;
        n_rejected++;
      end else begin
        // behind every entry of lower or equal priority value
        pos = 0;
        while (pos < queue_entries.size() && queue_entries[pos].prio <= r.priority_req)
          pos++;
        queue_entries.insert(pos, '{id: r.item_id, prio: r.priority_req});
        if (queue_entries.size() == QDEPTH)
          n_full_reached++;
      end
    end else begin
      n_remove++;
      if (queue_entries.size() == 0) begin
        res.was_empty = 1'b1;
        n_empty++;
      end else begin
        res.out_id = queue_entries[0].id;
        res.out_priority = queue_entries[0].prio;
        queue_entries.delete(0);
      end
    end
    res.occupancy = spq_pkg::OCC_W'(queue_entries.size());
    return res;
  endfunction

  function automatic spq_pkg::req_t make_req(logic op, logic [spq_pkg::ID_W-1:0] id,
                                             logic [spq_pkg::PRIO_W-1:0] prio);
    spq_pkg::req_t r;
    r.op = op;
    r.item_id = id;
    r.priority_req = prio;
    return r;
  endfunction

  // valid is only dropped when a gap follows, so back-to-back beats keep it high
  task automatic send_item(input spq_pkg::req_t item);
    int unsigned gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(queue_update(item));
    n_beats++;
  endtask

  task automatic check_rsp(input spq_pkg::rsp_t got);
    spq_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("response beat with nothing pending: %h", got);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.out_id !== want.out_id) begin
      $error("out_id expected %0h actual %0h", want.out_id, got.out_id);
      errors++;
    end
    if (got.out_priority !== want.out_priority) begin
      $error("out_priority expected %0h actual %0h", want.out_priority, got.out_priority);
      errors++;
    end
    if (got.was_empty !== want.was_empty) begin
      $error("was_empty expected %0b actual %0b", want.was_empty, got.was_empty);
      errors++;
    end
    if (got.was_full !== want.was_full) begin
      $error("was_full expected %0b actual %0b", want.was_full, got.was_full);
      errors++;
    end
    if (got.occupancy !== want.occupancy) begin
      $error("occupancy expected %0d actual %0d", want.occupancy, got.occupancy);
      errors++;
    end
  endtask

  // response side: random stall per beat plus any long hold asked for
  initial begin : rsp_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, snk_idle_max) + hold_request;
      hold_request = 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_rsp(rsp);
    end
  end

  task automatic test_directed();
    logic [spq_pkg::ID_W-1:0]   fill_id [16];
    logic [spq_pkg::PRIO_W-1:0] fill_prio [16];
    src_idle_max = 3;
    snk_idle_max = 3;
    fill_id = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hA5A5, 16'h5A5A,
                16'h0004, 16'h0005, 16'h0006, 16'h1234, 16'h8000, 16'h7FFF, 16'h0007,
                16'h0008, 16'h0009};
    fill_prio = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h01, 8'hFF,
                  8'h00, 8'h80, 8'hFE, 8'h40, 8'h40, 8'h10, 8'h10, 8'h0F};
    // remove on an empty queue, with the ignored fields all ones
    send_item(make_req(spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF));
    // fill up, with ties at both ends and in the middle
    for (int i = 0; i < 16; i++)
      send_item(make_req(spq_pkg::OP_INSERT, fill_id[i], fill_prio[i]));
    send_item(make_req(spq_pkg::OP_INSERT, 16'hBEEF, 8'h00));
    repeat (4) send_item(make_req(spq_pkg::OP_REMOVE, 16'h0000, 8'h00));
  endtask

  task automatic test_backpressure();
    src_idle_max = 0;
    snk_idle_max = 0;
    hold_request = HOLD_CYCLES;
    repeat (40)
      send_item(make_req(($urandom_range(0, 99) < 60) ? spq_pkg::OP_INSERT
                                                       : spq_pkg::OP_REMOVE,
                         spq_pkg::ID_W'($urandom), spq_pkg::PRIO_W'($urandom)));
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned                sent;
    int unsigned                phase_len;
    int unsigned                ins_pct;
    int unsigned                prio_mode;
    logic [spq_pkg::PRIO_W-1:0] p;
    logic                       op;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      prio_mode = $urandom_range(0, 2);
      src_idle_max = $urandom_range(0, 1) ? 17 : 0;
      snk_idle_max = $urandom_range(0, 1) ? 17 : 0;
      repeat (phase_len) begin
        case (prio_mode)
          0: p = spq_pkg::PRIO_W'($urandom);
          1: p = spq_pkg::PRIO_W'($urandom_range(0, 3));  // dense ties
          default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        send_item(make_req(op, spq_pkg::ID_W'($urandom), p));
        sent++;
      end
    end
  endtask

  initial begin : main_seq
    int unsigned guard;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1090);
    req_valid <= 1'b0;
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d response beats never arrived", pending_rsp.size());
      errors++;
    end
    $display("%0d request beats: %0d inserts (%0d refused on a full queue), %0d removes",
             n_beats, n_insert, n_rejected, n_remove);
    $display("%0d removes on empty; queue reached %0d entries %0d times; hold of %0d cycles",
             n_empty, QDEPTH, n_full_reached, HOLD_CYCLES);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
